[rtl/dpq_pkg.sv]
`timescale 1ns / 1ps

package dpq_pkg;

  // Data width of one stored value
  localparam int DATA_W = 32;

  // Width of the reported count
  localparam int COUNT_OUT_W = 7;

  // Action codes carried by an input word
  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEL_MAX = 2'd1,
    ACT_DEL_MIN = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  // Command broadcast to every cell of the sorted row
  typedef struct packed {
    logic                     ins;      // shift up above the insert point
    logic                     del_min;  // shift the whole row down by one
    logic signed [DATA_W-1:0] value;    // value being inserted
  } cell_cmd_t;

endpackage

[rtl/dpq_in_if.sv]
`timescale 1ns / 1ps

interface dpq_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

[rtl/dpq_out_if.sv]
`timescale 1ns / 1ps

interface dpq_out_if;
  logic               valid;
  logic               ready;
  logic               is_empty;
  logic signed [31:0] largest;
  logic signed [31:0] smallest;
  logic        [6:0]  entry_count;
  logic               dropped;

  modport source (output valid, output is_empty, output largest, output smallest,
                  output entry_count, output dropped, input ready);
  modport sink   (input valid, input is_empty, input largest, input smallest,
                  input entry_count, input dropped, output ready);
endinterface

[rtl/dpq_cell.sv]
`timescale 1ns / 1ps

module dpq_cell
  import dpq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [CNT_W-1:0]         count,
  input  logic                     below_le,   // neighbor below keeps its value
  input  logic signed [DATA_W-1:0] below_val,
  input  logic signed [DATA_W-1:0] above_val,
  output logic                     le_out,
  output logic signed [DATA_W-1:0] val_out,
  output logic signed [DATA_W-1:0] top_val     // own value when topmost, else 0
);

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     occupied;

  assign occupied = CNT_W'(IDX) < count;
  // Occupied and not above the new value: this cell stays put on insert
  assign le_out   = occupied && (val_r <= cmd.value);
  assign val_out  = val_r;
  assign top_val  = (CNT_W'(IDX + 1) == count) ? val_r : '0;

  // Next value: hold, take the new value, or shift from a neighbor
  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (le_out) begin
        val_nxt = val_r;
      end else if (below_le) begin
        val_nxt = cmd.value;
      end else begin
        val_nxt = below_val;
      end
    end else if (cmd.del_min) begin
      val_nxt = above_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[rtl/double_ended_priority_queue_unit.sv]
`timescale 1ns / 1ps

// Double-ended priority queue over a row of sorted cells.
// in_chan carries one word per operation: action (insert, delete largest,
// delete smallest, clear) and the value to insert. out_chan returns one word
// per operation: empty flag, largest, smallest, count and a dropped flag for
// an insert refused on a full queue.
// Cell k holds the k-th smallest value; an insert shifts every cell above the
// insert point up by one, a delete-smallest shifts the row down, a delete-largest
// or clear only moves the count.
// The row updates at the accept edge; the result word is then registered from
// the updated row into the output register, which raises out_chan.valid.
// in_chan.ready drops while the result is formed from the cell row and the
// one-hot top-cell select, so no new word is taken until the result is loaded.
// A result waiting on a stalled receiver does not block the next accept;
// that item updates the row and its result waits until the output register
// frees up, with in_chan.ready low meanwhile.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared and are never read unoccupied.
module double_ended_priority_queue_unit
  import dpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  dpq_in_if.sink           in_chan,
  dpq_out_if.source        out_chan
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     pend_r, pend_nxt;
  logic                     drop_r, drop_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_empty_r;
  logic signed [DATA_W-1:0] out_largest_r, out_smallest_r;
  logic [COUNT_OUT_W-1:0]   out_count_r;
  logic                     out_drop_r;

  logic                     accept, full, empty, load;
  action_t                  act;
  cell_cmd_t                cmd;

  logic                     le     [CAPACITY];
  logic signed [DATA_W-1:0] vals   [CAPACITY];
  logic signed [DATA_W-1:0] tops   [CAPACITY];
  logic signed [DATA_W-1:0] largest_c;

  assign in_chan.ready = !pend_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign act           = action_t'(in_chan.action);
  assign full          = count_r == CNT_W'(CAPACITY);
  assign empty         = count_r == '0;
  assign load          = pend_r && (!out_valid_r || out_chan.ready);

  // Decode the action into a row command and the new count
  always_comb begin
    cmd       = '{ins: 1'b0, del_min: 1'b0, value: in_chan.value};
    count_nxt = count_r;
    drop_nxt  = drop_r;
    pend_nxt  = pend_r;
    if (load) begin
      pend_nxt = 1'b0;
    end
    if (accept) begin
      pend_nxt = 1'b1;
      drop_nxt = 1'b0;
      case (act)
        ACT_INSERT: begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            cmd.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        ACT_DEL_MAX: begin
          if (!empty) count_nxt = count_r - 1'b1;
        end
        ACT_DEL_MIN: begin
          if (!empty) begin
            cmd.del_min = 1'b1;
            count_nxt   = count_r - 1'b1;
          end
        end
        ACT_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Sorted row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     b_le;
    logic signed [DATA_W-1:0] b_val, a_val;
    if (i == 0) begin : g_bot
      assign b_le  = 1'b1;
      assign b_val = '0;
    end else begin : g_mid
      assign b_le  = le[i-1];
      assign b_val = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign a_val = '0;
    end else begin : g_low
      assign a_val = vals[i+1];
    end
    dpq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .below_le  (b_le),
      .below_val (b_val),
      .above_val (a_val),
      .le_out    (le[i]),
      .val_out   (vals[i]),
      .top_val   (tops[i])
    );
  end

  // Only the topmost occupied cell drives a nonzero value
  always_comb begin
    largest_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest_c = largest_c | tops[i];
    end
  end

  // Output valid handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word, formed from the updated row
  always_ff @(posedge clk) begin
    drop_r <= drop_nxt;
    if (load) begin
      out_empty_r    <= empty;
      out_largest_r  <= largest_c;
      out_smallest_r <= empty ? '0 : vals[0];
      out_count_r    <= COUNT_OUT_W'(count_r);
      out_drop_r     <= drop_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.is_empty    = out_empty_r;
  assign out_chan.largest     = out_largest_r;
  assign out_chan.smallest    = out_smallest_r;
  assign out_chan.entry_count = out_count_r;
  assign out_chan.dropped     = out_drop_r;

endmodule

[rtl/dpq_checker.sv]
`timescale 1ns / 1ps

module dpq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_is_empty,
  input logic signed [31:0] out_largest,
  input logic signed [31:0] out_smallest,
  input logic        [6:0]  out_entry_count,
  input logic               out_dropped
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_largest) &&
    $stable(out_smallest) && $stable(out_entry_count))
    else $error("result word changed while stalled");

  // An empty queue reports zero count and zero extremes
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |->
    out_entry_count == 7'd0 && out_largest == 32'sd0 && out_smallest == 32'sd0)
    else $error("empty queue reports nonzero fields");

  // Extremes are ordered
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |-> out_smallest <= out_largest)
    else $error("smallest above largest");

  // A refused insert only happens on a full, hence nonempty, queue
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_is_empty)
    else $error("drop reported on empty queue");

endmodule

bind double_ended_priority_queue_unit dpq_checker u_dpq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_is_empty    (out_chan.is_empty),
  .out_largest     (out_chan.largest),
  .out_smallest    (out_chan.smallest),
  .out_entry_count (out_chan.entry_count),
  .out_dropped     (out_chan.dropped)
);

[tb/double_ended_priority_queue_unit_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the priority queue, keeps a sorted copy of the
// contents, and compares every returned word against the predicted status.
module double_ended_priority_queue_unit_checker
  import dpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  dpq_in_if     in_mon,
  dpq_out_if    out_mon,
  output int    mismatch_count,
  output int    pending_results
);

  // Status word as returned on the result channel
  typedef struct packed {
    logic                      is_empty;
    logic signed [DATA_W-1:0]  largest;
    logic signed [DATA_W-1:0]  smallest;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      dropped;
  } queue_status_t;

  // Shadow contents, ascending from index 0
  logic signed [DATA_W-1:0] held_values [CAPACITY];
  int                       held_count;
  queue_status_t            status_fifo [$];

  // Apply one action to the shadow contents and return the resulting status
  function automatic queue_status_t apply_action(action_t act,
                                                 logic signed [DATA_W-1:0] val);
    queue_status_t st;
    int            pos;
    st = '0;
    case (act)
      ACT_INSERT: begin
        if (held_count >= CAPACITY) begin
          st.dropped = 1'b1;
        end else begin
          // new value lands above its equals
          pos = 0;
          while (pos < held_count && held_values[pos] <= val) pos++;
          for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
          held_values[pos] = val;
          held_count++;
        end
      end
      ACT_DEL_MAX: begin
        if (held_count > 0) held_count--;
      end
      ACT_DEL_MIN: begin
        if (held_count > 0) begin
          for (int i = 0; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
          held_count--;
        end
      end
      default: begin
        held_count = 0;
      end
    endcase
    if (held_count == 0) begin
      st.is_empty = 1'b1;
    end else begin
      st.largest  = held_values[held_count-1];
      st.smallest = held_values[0];
    end
    st.entry_count = COUNT_OUT_W'(held_count);
    return st;
  endfunction

  task automatic compare_field(string name, logic [DATA_W-1:0] exp_val,
                               logic [DATA_W-1:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  // Accepted words on both channels, sampled at the rising edge
  always @(posedge clk) begin
    queue_status_t exp_st;
    if (!rst_n) begin
      held_count     = 0;
      mismatch_count = 0;
      status_fifo.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        status_fifo.push_back(apply_action(action_t'(in_mon.action), in_mon.value));
      if (out_mon.valid && out_mon.ready) begin
        if (status_fifo.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual empty=%0b max=%0h min=%0h",
                   $time, out_mon.is_empty, out_mon.largest, out_mon.smallest);
          mismatch_count++;
        end else begin
          exp_st = status_fifo.pop_front();
          compare_field("is_empty", DATA_W'(exp_st.is_empty), DATA_W'(out_mon.is_empty));
          compare_field("largest", exp_st.largest, out_mon.largest);
          compare_field("smallest", exp_st.smallest, out_mon.smallest);
          compare_field("entry_count", DATA_W'(exp_st.entry_count),
                        DATA_W'(out_mon.entry_count));
          compare_field("dropped", DATA_W'(exp_st.dropped), DATA_W'(out_mon.dropped));
        end
      end
    end
    pending_results = status_fifo.size();
  end

endmodule

[tb/double_ended_priority_queue_unit_tb.sv]
`timescale 1ns / 1ps

module double_ended_priority_queue_unit_tb;
  import dpq_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int TARGET_OPS  = 650;
  localparam int QUIET_AFTER = 560;   // no idling past this many words
  localparam int STALL_LIMIT = 500;   // cycles with no handshake at all

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_results;
  int   ops_sent;
  bit   idle_on;
  int   ready_hold   = 0;
  int   quiet_cycles = 0;

  dpq_in_if  in_chan ();
  dpq_out_if out_chan ();

  double_ended_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  double_ended_priority_queue_unit_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mix of full-range, clustered (duplicates) and extreme values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return $signed($urandom_range(0, 15)) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom);
    endcase
  endfunction

  // Present one word at the falling edge, hold until accepted
  task automatic send_word(action_t act, logic signed [31:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_chan.valid  = 1'b1;
    in_chan.action = act;
    in_chan.value  = val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    ops_sent++;
    if (ops_sent >= QUIET_AFTER) idle_on = 1'b0;
  endtask

  // Result side back-pressure in bursts
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_chan.ready = 1'b0;
      ready_hold--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_chan.ready = 1'b0;
      ready_hold = $urandom_range(0, 12);
    end else begin
      out_chan.ready = 1'b1;
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (rst_n && !(in_chan.valid && in_chan.ready) && !(out_chan.valid && out_chan.ready))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[double_ended_priority_queue_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int      seg_len;
    action_t act;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.action = ACT_INSERT;
    in_chan.value  = '0;
    ops_sent       = 0;
    idle_on        = 1'b1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: deletes and clear on empty, extremes, duplicates
    send_word(ACT_DEL_MAX, 32'sd0);
    send_word(ACT_DEL_MIN, -32'sd1);
    send_word(ACT_CLEAR, 32'sd0);
    send_word(ACT_INSERT, 32'sh7FFF_FFFF);
    send_word(ACT_INSERT, 32'sh8000_0000);
    send_word(ACT_INSERT, 32'sd0);
    send_word(ACT_INSERT, -32'sd1);
    send_word(ACT_INSERT, 32'sd1);
    send_word(ACT_INSERT, -32'sd1);
    send_word(ACT_INSERT, 32'sh7FFF_FFFF);
    send_word(ACT_DEL_MAX, 32'sh1234_5678);
    send_word(ACT_DEL_MIN, 32'sd0);
    send_word(ACT_DEL_MIN, 32'sd0);
    send_word(ACT_DEL_MAX, 32'sd0);
    send_word(ACT_INSERT, 32'shAAAA_AAAA);
    send_word(ACT_INSERT, 32'sh5555_5555);
    send_word(ACT_CLEAR, 32'shFFFF_FFFF);
    send_word(ACT_INSERT, 32'sd5);
    send_word(ACT_DEL_MIN, 32'sd0);
    send_word(ACT_DEL_MAX, 32'shFFFF_FFFF);
    send_word(ACT_INSERT, 32'sd7);
    send_word(ACT_DEL_MAX, 32'sd0);

    // Random segments; the first one always fills to capacity
    seg_len = 0;
    while (ops_sent < TARGET_OPS) begin
      case ((seg_len == 0) ? 0 : $urandom_range(0, 9))
        0, 1, 2: begin
          // fill until full, possibly followed by refused inserts
          if ($urandom_range(0, 1) == 0) send_word(ACT_CLEAR, pick_value());
          repeat ($urandom_range(CAPACITY, CAPACITY + 8)) send_word(ACT_INSERT, pick_value());
        end
        3, 4: begin
          // drain from either end, often past empty
          repeat ($urandom_range(5, CAPACITY + 6)) begin
            act = ($urandom_range(0, 1) == 0) ? ACT_DEL_MAX : ACT_DEL_MIN;
            send_word(act, pick_value());
          end
        end
        5, 6, 7, 8: begin
          // insert-heavy mix with occasional clear
          repeat ($urandom_range(10, 40)) begin
            case ($urandom_range(0, 99)) inside
              [0:51]:  act = ACT_INSERT;
              [52:74]: act = ACT_DEL_MAX;
              [75:97]: act = ACT_DEL_MIN;
              default: act = ACT_CLEAR;
            endcase
            send_word(act, pick_value());
          end
        end
        default: begin
          // noise: any action, any value
          repeat ($urandom_range(5, 15))
            send_word(action_t'($urandom_range(0, 3)), $signed($urandom));
        end
      endcase
      seg_len++;
    end
    in_chan.valid = 1'b0;

    // Drain outstanding results, then a short tail
    while (pending_results != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("[double_ended_priority_queue_unit] OK");
    end else begin
      $display("[double_ended_priority_queue_unit] ERROR");
    end
    $finish;
  end

endmodule
